### hw/rtl/bps_pkg.sv
// bps_pkg: shared types and constants of the bilinear pixel sampler
// no dependencies; used by bps_front, bps_back and bilinear_pixel_sampler
`timescale 1ns / 1ps

package bps_pkg;

    // field widths fixed by the item format
    localparam int COORD_W    = 20;
    localparam int PIX_W      = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 9;

    // signed width used for the bounds compares
    localparam int CMP_W = 22;

    // size registers come out of reset at full frame
    localparam logic [CFG_DATA_W-1:0] RESET_SIZE = 9'd256;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

    // item kinds
    typedef enum logic {
        BPS_OP_LOAD   = 1'b0,
        BPS_OP_SAMPLE = 1'b1
    } bps_op_t;

    // classification handed from front to back through the queue
    typedef struct packed {
        bps_op_t op;
        logic    in_area;
        logic    col_odd;
        logic    row_odd;
    } bps_ctl_t;

    localparam int CTL_W = $bits(bps_ctl_t);

endpackage

### hw/rtl/bps_ram.sv
// bps_ram: generic single-write, single-read memory with registered read data
// no dependencies
`timescale 1ns / 1ps

module bps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/bps_queue.sv
// bps_queue: short fifo between the classifying front and the blending back
// no dependencies
`timescale 1ns / 1ps

module bps_queue #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty,
    output logic             full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = entry_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### hw/rtl/bps_front.sv
// bps_front: size registers and classification of each accepted beat
// depends on bps_pkg
`timescale 1ns / 1ps

module bps_front #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [bps_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [bps_pkg::CFG_DATA_W-1:0]          cfg_data,
    input  logic                                    command,
    input  logic [bps_pkg::PIX_W-1:0]               load_col,
    input  logic [bps_pkg::PIX_W-1:0]               load_row,
    input  logic [bps_pkg::PIX_W-1:0]               load_value,
    input  logic signed [bps_pkg::COORD_W-1:0]      sample_x,
    input  logic signed [bps_pkg::COORD_W-1:0]      sample_y,
    output bps_pkg::bps_ctl_t                       ctl,
    output logic [((($clog2(MAX_WIDTH)) > 1) ? $clog2(MAX_WIDTH) - 1 : 1)-1:0]   col_even_half,
    output logic [((($clog2(MAX_WIDTH)) > 1) ? $clog2(MAX_WIDTH) - 1 : 1)-1:0]   col_odd_half,
    output logic [((($clog2(MAX_HEIGHT)) > 1) ? $clog2(MAX_HEIGHT) - 1 : 1)-1:0] row_even_half,
    output logic [((($clog2(MAX_HEIGHT)) > 1) ? $clog2(MAX_HEIGHT) - 1 : 1)-1:0] row_odd_half,
    output logic [bps_pkg::PIX_W-1:0]               pix_value,
    output logic signed [FRAC_BITS:0]               frac_x,
    output logic signed [FRAC_BITS:0]               frac_y
);

    localparam int IW    = bps_pkg::COORD_W - FRAC_BITS;
    localparam int CMP_W = bps_pkg::CMP_W;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int RW    = $clog2(MAX_HEIGHT);
    localparam int CHW   = (CW > 1) ? CW - 1 : 1;
    localparam int RHW   = (RW > 1) ? RW - 1 : 1;

    logic [bps_pkg::CFG_DATA_W-1:0] width_reg, width_next;
    logic [bps_pkg::CFG_DATA_W-1:0] height_reg, height_next;

    logic                    round_x, round_y;
    logic signed [IW-1:0]    ix_floor, iy_floor, ix, iy;
    logic signed [CMP_W-1:0] ix_c, iy_c, w_eff, h_eff, w_lim, h_lim;
    logic                    inside_x, inside_y;
    logic [CW-1:0]           ix_col, ld_col;
    logic [RW-1:0]           iy_row, ld_row;
    logic                    load_ok;

    // size register writes
    always_comb
    begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                bps_pkg::REG_IMAGE_WIDTH:  width_next  = cfg_data;
                bps_pkg::REG_IMAGE_HEIGHT: height_next = cfg_data;
                default:                   width_next  = width_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bps_pkg::RESET_SIZE;
            height_reg <= bps_pkg::RESET_SIZE;
        end
        else
        begin
            width_reg  <= width_next;
            height_reg <= height_next;
        end
    end

    // integer part truncated toward zero, signed fraction
    assign round_x  = sample_x[bps_pkg::COORD_W-1] && (sample_x[FRAC_BITS-1:0] != '0);
    assign round_y  = sample_y[bps_pkg::COORD_W-1] && (sample_y[FRAC_BITS-1:0] != '0);
    assign ix_floor = IW'(sample_x >>> FRAC_BITS);
    assign iy_floor = IW'(sample_y >>> FRAC_BITS);
    assign ix       = ix_floor + {{(IW-1){1'b0}}, round_x};
    assign iy       = iy_floor + {{(IW-1){1'b0}}, round_y};
    assign ix_c     = CMP_W'(ix);
    assign iy_c     = CMP_W'(iy);

    // effective size clamped to the store, last interpolable index
    assign w_eff = (CMP_W'(width_reg) > CMP_W'(MAX_WIDTH))
                 ? CMP_W'(MAX_WIDTH) : CMP_W'(width_reg);
    assign h_eff = (CMP_W'(height_reg) > CMP_W'(MAX_HEIGHT))
                 ? CMP_W'(MAX_HEIGHT) : CMP_W'(height_reg);
    assign w_lim = w_eff - CMP_W'(2);
    assign h_lim = h_eff - CMP_W'(2);

    assign inside_x = !ix_c[CMP_W-1] && (ix_c <= w_lim);
    assign inside_y = !iy_c[CMP_W-1] && (iy_c <= h_lim);

    // neighbor coordinates, valid only when inside
    assign ix_col = ix_c[CW-1:0];
    assign iy_row = iy_c[RW-1:0];

    // load position, dropped when beyond the store
    assign load_ok = (CMP_W'(load_col) < CMP_W'(MAX_WIDTH))
                  && (CMP_W'(load_row) < CMP_W'(MAX_HEIGHT));
    assign ld_col  = CW'(load_col);
    assign ld_row  = RW'(load_row);

    // per-kind classification
    always_comb
    begin
        pix_value = load_value;
        frac_x    = {round_x, sample_x[FRAC_BITS-1:0]};
        frac_y    = {round_y, sample_y[FRAC_BITS-1:0]};
        ctl.op    = bps_pkg::bps_op_t'(command);
        if (command == bps_pkg::BPS_OP_SAMPLE)
        begin
            ctl.in_area   = inside_x && inside_y;
            ctl.col_odd   = ix_col[0];
            ctl.row_odd   = iy_row[0];
            col_odd_half  = CHW'(ix_col >> 1);
            col_even_half = CHW'((ix_col + CW'(ix_col[0])) >> 1);
            row_odd_half  = RHW'(iy_row >> 1);
            row_even_half = RHW'((iy_row + RW'(iy_row[0])) >> 1);
        end
        else
        begin
            ctl.in_area   = load_ok;
            ctl.col_odd   = ld_col[0];
            ctl.row_odd   = ld_row[0];
            col_odd_half  = CHW'(ld_col >> 1);
            col_even_half = CHW'(ld_col >> 1);
            row_odd_half  = RHW'(ld_row >> 1);
            row_even_half = RHW'(ld_row >> 1);
        end
    end

endmodule

### hw/rtl/bps_back.sv
// bps_back: parity-banked pixel store and the bilinear blend pipeline
// depends on bps_pkg and bps_ram
`timescale 1ns / 1ps

module bps_back #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    entry_valid,
    input  bps_pkg::bps_ctl_t                       ctl,
    input  logic [((($clog2(MAX_WIDTH)) > 1) ? $clog2(MAX_WIDTH) - 1 : 1)-1:0]   col_even_half,
    input  logic [((($clog2(MAX_WIDTH)) > 1) ? $clog2(MAX_WIDTH) - 1 : 1)-1:0]   col_odd_half,
    input  logic [((($clog2(MAX_HEIGHT)) > 1) ? $clog2(MAX_HEIGHT) - 1 : 1)-1:0] row_even_half,
    input  logic [((($clog2(MAX_HEIGHT)) > 1) ? $clog2(MAX_HEIGHT) - 1 : 1)-1:0] row_odd_half,
    input  logic [bps_pkg::PIX_W-1:0]               pix_value,
    input  logic signed [FRAC_BITS:0]               frac_x,
    input  logic signed [FRAC_BITS:0]               frac_y,
    output logic                                    done,
    output logic [bps_pkg::PIX_W-1:0]               sample_value,
    output logic                                    inside_res
);

    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int RW      = $clog2(MAX_HEIGHT);
    localparam int CHW     = (CW > 1) ? CW - 1 : 1;
    localparam int RHW     = (RW > 1) ? RW - 1 : 1;
    localparam int BANK_AW = CHW + RHW;
    localparam int BANK_D  = 2 ** BANK_AW;
    localparam int FW      = FRAC_BITS + 1;
    localparam int PW      = FRAC_BITS + 10;
    localparam int XW      = 2 * FRAC_BITS + 2;
    localparam int P3W     = 2 * FRAC_BITS + 13;
    localparam int AW      = 2 * FRAC_BITS + 14;
    localparam int QW      = AW - 2 * FRAC_BITS;
    localparam int PIX_W   = bps_pkg::PIX_W;

    logic [PIX_W-1:0] bank_q [4];
    logic             is_load, is_sample;

    assign is_load   = entry_valid && (ctl.op == bps_pkg::BPS_OP_LOAD);
    assign is_sample = entry_valid && (ctl.op == bps_pkg::BPS_OP_SAMPLE);

    // four banks by row and column parity: bank index is {row odd, col odd}
    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic                 we;
        logic [BANK_AW-1:0]   waddr, raddr;
        logic [RHW-1:0]       rd_row;
        logic [CHW-1:0]       rd_col;

        assign we     = is_load && ctl.in_area && ({ctl.row_odd, ctl.col_odd} == 2'(b));
        assign waddr  = {row_even_half, col_even_half};
        assign rd_row = (b / 2 == 1) ? row_odd_half : row_even_half;
        assign rd_col = (b % 2 == 1) ? col_odd_half : col_even_half;
        assign raddr  = {rd_row, rd_col};

        bps_ram #(
            .WIDTH (PIX_W),
            .DEPTH (BANK_D)
        ) u_ram (
            .clk   (clk),
            .we    (we),
            .waddr (waddr),
            .wdata (pix_value),
            .raddr (raddr),
            .rdata (bank_q[b])
        );
    end

    // stage 1: bank read in flight, carry classification and fractions
    logic                 s1_valid_reg, s1_valid_next;
    logic                 s1_inside_reg, s1_col_odd_reg, s1_row_odd_reg;
    logic signed [FW-1:0] s1_fx_reg, s1_fy_reg;

    assign s1_valid_next = is_sample;

    always_ff @(posedge clk)
    begin
        s1_inside_reg  <= ctl.in_area;
        s1_col_odd_reg <= ctl.col_odd;
        s1_row_odd_reg <= ctl.row_odd;
        s1_fx_reg      <= frac_x;
        s1_fy_reg      <= frac_y;
    end

    // undo the parity swizzle: columns first, then rows
    logic [PIX_W-1:0] even_l, even_r, odd_l, odd_r;
    logic [PIX_W-1:0] v00, v10, v01, v11;

    assign even_l = s1_col_odd_reg ? bank_q[1] : bank_q[0];
    assign even_r = s1_col_odd_reg ? bank_q[0] : bank_q[1];
    assign odd_l  = s1_col_odd_reg ? bank_q[3] : bank_q[2];
    assign odd_r  = s1_col_odd_reg ? bank_q[2] : bank_q[3];
    assign v00    = s1_row_odd_reg ? odd_l  : even_l;
    assign v10    = s1_row_odd_reg ? odd_r  : even_r;
    assign v01    = s1_row_odd_reg ? even_l : odd_l;
    assign v11    = s1_row_odd_reg ? even_r : odd_r;

    // stage 2: differences and the three first products
    logic signed [8:0]    d10, d01;
    logic signed [10:0]   dd;
    logic signed [PW-1:0] fx_w, fy_w, d10_w, d01_w;
    logic signed [XW-1:0] fx_x, fy_x;

    assign d10   = 9'(v10) - 9'(v00);
    assign d01   = 9'(v01) - 9'(v00);
    assign dd    = 11'(v01) - 11'(v00) + 11'(v10) - 11'(v11);
    assign fx_w  = PW'(s1_fx_reg);
    assign fy_w  = PW'(s1_fy_reg);
    assign d10_w = PW'(d10);
    assign d01_w = PW'(d01);
    assign fx_x  = XW'(s1_fx_reg);
    assign fy_x  = XW'(s1_fy_reg);

    logic                 s2_valid_reg, s2_inside_reg;
    logic signed [PW-1:0] s2_p1_reg, s2_p1_next, s2_p2_reg, s2_p2_next;
    logic signed [XW-1:0] s2_pxy_reg, s2_pxy_next;
    logic signed [10:0]   s2_dd_reg;
    logic [PIX_W-1:0]     s2_v00_reg;

    assign s2_p1_next  = fx_w * d10_w;
    assign s2_p2_next  = fy_w * d01_w;
    assign s2_pxy_next = fx_x * fy_x;

    always_ff @(posedge clk)
    begin
        s2_inside_reg <= s1_inside_reg;
        s2_p1_reg     <= s2_p1_next;
        s2_p2_reg     <= s2_p2_next;
        s2_pxy_reg    <= s2_pxy_next;
        s2_dd_reg     <= dd;
        s2_v00_reg    <= v00;
    end

    // stage 3: cross product and the sum of the linear terms
    logic signed [P3W-1:0] pxy_w, dd_w;
    logic signed [AW-1:0]  lin_sum;

    assign pxy_w   = P3W'(s2_pxy_reg);
    assign dd_w    = P3W'(s2_dd_reg);
    assign lin_sum = AW'(s2_p1_reg) + AW'(s2_p2_reg);

    logic                  s3_valid_reg, s3_inside_reg;
    logic signed [AW-1:0]  s3_base_reg, s3_base_next;
    logic signed [P3W-1:0] s3_p3_reg, s3_p3_next;

    assign s3_base_next = (AW'(s2_v00_reg) << (2 * FRAC_BITS)) + (lin_sum << FRAC_BITS);
    assign s3_p3_next   = pxy_w * dd_w;

    always_ff @(posedge clk)
    begin
        s3_inside_reg <= s2_inside_reg;
        s3_base_reg   <= s3_base_next;
        s3_p3_reg     <= s3_p3_next;
    end

    // stage 4: full accumulator
    logic                 s4_valid_reg, s4_inside_reg;
    logic signed [AW-1:0] s4_acc_reg, s4_acc_next;

    assign s4_acc_next = s3_base_reg - AW'(s3_p3_reg);

    always_ff @(posedge clk)
    begin
        s4_inside_reg <= s3_inside_reg;
        s4_acc_reg    <= s4_acc_next;
    end

    // output: truncate toward zero and saturate; a negative sum lands on zero
    logic [QW-1:0]    quo;
    logic [PIX_W-1:0] sat;
    logic             done_reg, done_next;
    logic [PIX_W-1:0] value_reg, value_next;
    logic             inside_reg, inside_next;

    assign quo         = s4_acc_reg[AW-1:2*FRAC_BITS];
    assign sat         = (quo > QW'(255)) ? 8'hFF : quo[PIX_W-1:0];
    assign done_next   = s4_valid_reg;
    assign inside_next = s4_inside_reg;
    assign value_next  = (s4_inside_reg && !s4_acc_reg[AW-1]) ? sat : '0;

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        inside_reg <= inside_next;
    end

    // pipeline valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
            done_reg     <= done_next;
        end
    end

    assign done         = done_reg;
    assign sample_value = value_reg;
    assign inside_res   = inside_reg;

endmodule

### hw/rtl/bilinear_pixel_sampler.sv
// Results: a sample beat taken into the queue passes the bank read, the blend stages
// and the output register, then shows with done high; loads give no result.
// Throughput: one beat per clock while busy is low; the four neighbors come from four
// parity banks read in the same cycle, and the bank read and blend form a five-stage
// multiplier pipeline. Reset: size registers return to 256, queue and pipeline empty;
// the pixel store is not cleared and holds garbage until written. busy is queue full.
`timescale 1ns / 1ps

module bilinear_pixel_sampler #(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                cfg_we,
    input  logic [bps_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bps_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                command,
    input  logic [bps_pkg::PIX_W-1:0]           load_col,
    input  logic [bps_pkg::PIX_W-1:0]           load_row,
    input  logic [bps_pkg::PIX_W-1:0]           load_value,
    input  logic signed [bps_pkg::COORD_W-1:0]  sample_x,
    input  logic signed [bps_pkg::COORD_W-1:0]  sample_y,
    output logic                                done,
    output logic [bps_pkg::PIX_W-1:0]           sample_value,
    output logic                                inside_res
);

    localparam int CW      = $clog2(MAX_WIDTH);
    localparam int RW      = $clog2(MAX_HEIGHT);
    localparam int CHW     = (CW > 1) ? CW - 1 : 1;
    localparam int RHW     = (RW > 1) ? RW - 1 : 1;
    localparam int FW      = FRAC_BITS + 1;
    localparam int Q_WIDTH = bps_pkg::CTL_W + 2 * CHW + 2 * RHW + bps_pkg::PIX_W + 2 * FW;
    localparam int Q_DEPTH = 2;

    // front outputs
    bps_pkg::bps_ctl_t    f_ctl;
    logic [CHW-1:0]       f_col_even, f_col_odd;
    logic [RHW-1:0]       f_row_even, f_row_odd;
    logic [bps_pkg::PIX_W-1:0] f_value;
    logic signed [FW-1:0] f_fx, f_fy;

    // queue head
    bps_pkg::bps_ctl_t    b_ctl;
    logic [CHW-1:0]       b_col_even, b_col_odd;
    logic [RHW-1:0]       b_row_even, b_row_odd;
    logic [bps_pkg::PIX_W-1:0] b_value;
    logic signed [FW-1:0] b_fx, b_fy;

    logic [Q_WIDTH-1:0] q_wdata, q_rdata;
    logic               q_empty, q_full, accept;

    assign busy   = q_full;
    assign accept = start && !q_full;

    // classify the beat
    bps_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .command       (command),
        .load_col      (load_col),
        .load_row      (load_row),
        .load_value    (load_value),
        .sample_x      (sample_x),
        .sample_y      (sample_y),
        .ctl           (f_ctl),
        .col_even_half (f_col_even),
        .col_odd_half  (f_col_odd),
        .row_even_half (f_row_even),
        .row_odd_half  (f_row_odd),
        .pix_value     (f_value),
        .frac_x        (f_fx),
        .frac_y        (f_fy)
    );

    // queue between front and back
    assign q_wdata = {f_ctl, f_col_even, f_col_odd, f_row_even, f_row_odd,
                      f_value, f_fx, f_fy};
    assign {b_ctl, b_col_even, b_col_odd, b_row_even, b_row_odd,
            b_value, b_fx, b_fy} = q_rdata;

    bps_queue #(
        .WIDTH (Q_WIDTH),
        .DEPTH (Q_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (accept),
        .wdata (q_wdata),
        .pop   (!q_empty),
        .rdata (q_rdata),
        .empty (q_empty),
        .full  (q_full)
    );

    // store access and blend
    bps_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .entry_valid   (!q_empty),
        .ctl           (b_ctl),
        .col_even_half (b_col_even),
        .col_odd_half  (b_col_odd),
        .row_even_half (b_row_even),
        .row_odd_half  (b_row_odd),
        .pix_value     (b_value),
        .frac_x        (b_fx),
        .frac_y        (b_fy),
        .done          (done),
        .sample_value  (sample_value),
        .inside_res    (inside_res)
    );

endmodule
